### rtl/core/polyphonic_voice_synth_defines.svh
// Assertion macros for the synthesizer RTL.
// Users must have clk_i and rst_ni in scope.
`ifndef POLYPHONIC_VOICE_SYNTH_DEFINES_SVH
`define POLYPHONIC_VOICE_SYNTH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PVS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PVS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pvs_pkg.sv
// Package for the polyphonic voice synthesizer: sizes, payload types and codes.
// No dependencies.
`timescale 1ns / 1ps
package pvs_pkg;

  localparam int unsigned VOICE_COUNT    = 16;
  localparam int unsigned QUEUE_DEPTH    = 16;
  localparam int unsigned SINE_ADDR_BITS = 10;

  localparam int unsigned VW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ACC_W = 49 + $clog2(VOICE_COUNT + 1);

  localparam logic [16:0] LEVEL_FULL = 17'd65536;
  localparam logic [47:0] FRAME_MAX  = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes.
  localparam logic REG_RAMP_STEP      = 1'b0;
  localparam logic REG_RELEASE_FRAMES = 1'b1;

  typedef enum logic [1:0] {
    ENV_IDLE    = 2'd0,
    ENV_ATTACK  = 2'd1,
    ENV_SUSTAIN = 2'd2,
    ENV_RELEASE = 2'd3
  } env_e;

  typedef struct packed {
    logic        mode;
    logic [47:0] start_frame;
    logic [31:0] duration_frames;
    logic [31:0] phase_step;
    logic [15:0] volume;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               queue_overflow;
  } result_t;

  typedef struct packed {
    logic [47:0] start;
    logic [31:0] dur;
    logic [31:0] step;
    logic [15:0] vol;
  } note_t;

  typedef struct packed {
    logic  is_tick;
    note_t note;
  } cmd_t;

  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } sine_t;

endpackage

### rtl/core/polyphonic_voice_synth.sv
// Polyphonic voice synthesizer, top level. A tick beat fires each due
// event (the steal search walks the voices one per cycle), then walks the
// voices and passes each sounding voice through the five-step shared
// multiplier of the sine unit and the two product stages. Input beats
// buffer in a two-entry queue and samples in a two-entry queue.
// Depends on pvs_pkg, pvs_front and pvs_back.
`timescale 1ns / 1ps
module polyphonic_voice_synth import pvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    item_i,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  pvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

### rtl/core/pvs_front.sv
// Front end: accepts input beats, classifies them into commands and buffers
// them in a two-entry queue toward the engine. Depends on pvs_pkg.
`timescale 1ns / 1ps
module pvs_front import pvs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  cmd_t        ent_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;
  cmd_t        cmd_new;

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = ent_q[rd_q];

  always_comb begin
    cmd_new.is_tick    = item_i.mode;
    cmd_new.note.start = item_i.start_frame;
    cmd_new.note.dur   = item_i.duration_frames;
    cmd_new.note.step  = item_i.phase_step;
    cmd_new.note.vol   = item_i.volume;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### rtl/core/pvs_sine.sv
// Iterative sine unit: evaluates the quarter-wave polynomial with one shared
// 17x17 multiplier over five steps. Depends on pvs_pkg.
`timescale 1ns / 1ps
module pvs_sine import pvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] phase_i,
  output logic        done_o,
  output sine_t       sine_o
);

  localparam int unsigned QB = SINE_ADDR_BITS - 2;

  localparam logic [2:0] SQ_T2   = 3'd0;
  localparam logic [2:0] SQ_P1   = 3'd1;
  localparam logic [2:0] SQ_P2   = 3'd2;
  localparam logic [2:0] SQ_P3   = 3'd3;
  localparam logic [2:0] SQ_LAST = 3'd4;

  logic [SINE_ADDR_BITS-1:0] idx;
  logic [1:0]  quad;
  logic [QB:0] r;
  logic [16:0] t;
  logic [16:0] ma_q, mb_q, t_q;
  logic [33:0] prod;
  logic [16:0] hi;
  logic [17:0] s_full;
  logic [2:0]  step_q;
  logic        busy_q, done_q, neg_q;
  logic [14:0] mag_q;

  assign idx  = phase_i[31 -: SINE_ADDR_BITS];
  assign quad = idx[SINE_ADDR_BITS-1 -: 2];

  always_comb begin
    r = {1'b0, idx[QB-1:0]};
    if (quad[0]) r = (QB+1)'(1 << QB) - r;
    t = 17'(r) << (16 - QB);
  end

  assign prod   = 34'(ma_q) * 34'(mb_q);
  assign hi     = prod[32:16];
  assign s_full = (18'(hi) + 18'd1) >> 1;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= t;
      mb_q  <= t;
      t_q   <= t;
      neg_q <= quad[1];
    end else if (busy_q) begin
      case (step_q)
        SQ_T2: begin
          ma_q <= hi;
          mb_q <= 17'd307;
        end
        SQ_P1: mb_q <= 17'd5223 - hi;
        SQ_P2: mb_q <= 17'd42334 - hi;
        SQ_P3: begin
          ma_q <= t_q;
          mb_q <= 17'd102944 - hi;
        end
        default: mag_q <= (s_full > 18'd32767) ? 15'h7FFF : s_full[14:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= SQ_T2;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == SQ_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SQ_T2;
      end else if (busy_q) begin
        if (step_q == SQ_LAST) busy_q <= 1'b0;
        step_q <= step_q + 3'd1;
      end
    end
  end

  assign done_o     = done_q;
  assign sine_o.neg = neg_q;
  assign sine_o.mag = mag_q;

endmodule

### rtl/core/pvs_back.sv
// Engine: owns the event queue, the voices and the configuration, fires due
// events, walks the voices per tick and queues the mixed samples.
// Depends on pvs_pkg, pvs_sine and the assertion macro header.
`timescale 1ns / 1ps
`include "polyphonic_voice_synth_defines.svh"
module pvs_back import pvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_FIRE   = 10'b00_0000_0010,
    ST_SCAN   = 10'b00_0000_0100,
    ST_ASSIGN = 10'b00_0000_1000,
    ST_ENV    = 10'b00_0001_0000,
    ST_SINE   = 10'b00_0010_0000,
    ST_MUL1   = 10'b00_0100_0000,
    ST_MUL2   = 10'b00_1000_0000,
    ST_ACC    = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_e;

  state_e state_q;

  logic [16:0] ramp_q;
  logic [15:0] rel_q;
  logic        ovf_q;
  logic [47:0] frame_q;

  note_t            ev_q [QUEUE_DEPTH];
  logic [QIW-1:0]   head_q, tail_q;
  logic [QCW-1:0]   ev_cnt_q;

  logic [31:0] v_phase_q [VOICE_COUNT];
  logic [31:0] v_step_q  [VOICE_COUNT];
  logic [15:0] v_vol_q   [VOICE_COUNT];
  logic [16:0] v_lvl_q   [VOICE_COUNT];
  env_e        v_env_q   [VOICE_COUNT];
  logic [31:0] v_left_q  [VOICE_COUNT];

  logic [VW-1:0] vidx_q, best_q, pick_q;
  logic [16:0]   best_lvl_q;
  logic          vlast;

  logic [15:0] w_vol_q;
  logic [16:0] w_lvl_q;
  logic [30:0] prod1_q;
  logic [47:0] prod2_q;
  logic        w_neg_q;
  logic signed [ACC_W-1:0] acc_q;

  logic        sine_start, sine_done;
  sine_t       sine_res;

  // Result queue, two entries.
  result_t     res_q [2];
  logic        res_wr_q, res_rd_q;
  logic [1:0]  res_cnt_q;
  logic        res_push, res_pop;
  result_t     res_new;

  logic        cmd_pop;
  note_t       head_ev;
  logic        due;

  env_e        cur_env, nx_env;
  logic [16:0] cur_lvl, nx_lvl;
  logic [31:0] cur_left, nx_left;
  logic [17:0] lvl_sum;
  logic        contrib;

  logic [ACC_W-1:0] acc_mag;
  logic [ACC_W:0]   q_round;

  assign vlast   = (vidx_q == VW'(VOICE_COUNT - 1));
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign cmd_pop = cmd_valid_i && cmd_ready_o;
  assign head_ev = ev_q[head_q];
  assign due     = (ev_cnt_q != '0) && (frame_q >= head_ev.start);

  assign cur_env  = v_env_q[vidx_q];
  assign cur_lvl  = v_lvl_q[vidx_q];
  assign cur_left = v_left_q[vidx_q];

  // Envelope step for the voice under the walk index.
  always_comb begin
    nx_env  = cur_env;
    nx_lvl  = cur_lvl;
    nx_left = cur_left;
    lvl_sum = 18'(cur_lvl) + 18'(ramp_q);
    if (cur_env != ENV_RELEASE) begin
      if (cur_left == 32'd0) begin
        nx_env = ENV_RELEASE;
      end else begin
        nx_left = cur_left - 32'd1;
        if (cur_env == ENV_ATTACK) begin
          if (lvl_sum >= 18'(LEVEL_FULL)) begin
            nx_lvl = LEVEL_FULL;
            nx_env = ENV_SUSTAIN;
          end else begin
            nx_lvl = lvl_sum[16:0];
          end
        end
      end
    end
    if (nx_env == ENV_RELEASE) begin
      if (nx_lvl <= ramp_q) begin
        nx_lvl = 17'd0;
        nx_env = ENV_IDLE;
      end else begin
        nx_lvl = nx_lvl - ramp_q;
      end
    end
    contrib = (cur_env != ENV_IDLE) && (nx_env != ENV_IDLE);
  end

  assign sine_start = (state_q == ST_ENV) && contrib;

  pvs_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sine_start),
    .phase_i (v_phase_q[vidx_q]),
    .done_o  (sine_done),
    .sine_o  (sine_res)
  );

  // Round half away from zero, then clip to Q1.15.
  always_comb begin
    acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    q_round = ((ACC_W+1)'(acc_mag) + (ACC_W+1)'(1 << 30)) >> 31;
    res_new.queue_overflow = ovf_q;
    if (!acc_q[ACC_W-1]) begin
      res_new.sample = (q_round > (ACC_W+1)'(32767)) ? 16'sh7FFF : 16'(q_round);
    end else begin
      res_new.sample = (q_round > (ACC_W+1)'(32768)) ? 16'sh8000 : 16'(-q_round);
    end
  end

  assign res_push = (state_q == ST_OUT) && (res_cnt_q != 2'd2);
  assign empty    = (res_cnt_q == 2'd0);
  assign res_pop  = pop && !empty;
  assign result_o = res_q[res_rd_q];

  always_ff @(posedge clk_i) begin
    if (res_push) res_q[res_wr_q] <= res_new;
    if (cmd_pop && !cmd_i.is_tick && (ev_cnt_q != QCW'(QUEUE_DEPTH))) begin
      ev_q[tail_q] <= cmd_i.note;
    end
    unique case (state_q)
      ST_ENV: begin
        w_vol_q <= v_vol_q[vidx_q];
        w_lvl_q <= nx_lvl;
      end
      ST_SINE: w_neg_q <= sine_res.neg;
      ST_MUL1: prod1_q <= 31'(sine_res.mag) * 31'(w_vol_q);
      ST_MUL2: prod2_q <= 48'(prod1_q) * 48'(w_lvl_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ramp_q     <= 17'd273;
      rel_q      <= 16'd240;
      ovf_q      <= 1'b0;
      frame_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      ev_cnt_q   <= '0;
      vidx_q     <= '0;
      best_q     <= '0;
      pick_q     <= '0;
      best_lvl_q <= '0;
      acc_q      <= '0;
      res_wr_q   <= 1'b0;
      res_rd_q   <= 1'b0;
      res_cnt_q  <= 2'd0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        v_phase_q[i] <= '0;
        v_step_q[i]  <= '0;
        v_vol_q[i]   <= '0;
        v_lvl_q[i]   <= '0;
        v_env_q[i]   <= ENV_IDLE;
        v_left_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RAMP_STEP:      ramp_q <= cfg_wdata_i;
          REG_RELEASE_FRAMES: rel_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (res_push) res_wr_q <= ~res_wr_q;
      if (res_pop)  res_rd_q <= ~res_rd_q;
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);

      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd_i.is_tick) begin
              acc_q   <= '0;
              state_q <= ST_FIRE;
            end else if (ev_cnt_q == QCW'(QUEUE_DEPTH)) begin
              ovf_q <= 1'b1;
            end else begin
              tail_q   <= (tail_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QIW'(1);
              ev_cnt_q <= ev_cnt_q + QCW'(1);
            end
          end
        end
        ST_FIRE: begin
          vidx_q  <= '0;
          state_q <= due ? ST_SCAN : ST_ENV;
        end
        ST_SCAN: begin
          // First idle voice wins; otherwise the lowest level, lowest index.
          if (cur_env == ENV_IDLE) begin
            pick_q  <= vidx_q;
            state_q <= ST_ASSIGN;
          end else begin
            if ((vidx_q == '0) || (cur_lvl < best_lvl_q)) begin
              best_q     <= vidx_q;
              best_lvl_q <= cur_lvl;
            end
            if (vlast) begin
              pick_q  <= ((vidx_q == '0) || (cur_lvl < best_lvl_q)) ? vidx_q : best_q;
              state_q <= ST_ASSIGN;
            end else begin
              vidx_q <= vidx_q + VW'(1);
            end
          end
        end
        ST_ASSIGN: begin
          v_step_q[pick_q] <= head_ev.step;
          v_vol_q[pick_q]  <= head_ev.vol;
          v_left_q[pick_q] <= (head_ev.dur > 32'(rel_q)) ? head_ev.dur - 32'(rel_q) : 32'd0;
          v_env_q[pick_q]  <= ENV_ATTACK;
          head_q   <= (head_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIW'(1);
          ev_cnt_q <= ev_cnt_q - QCW'(1);
          state_q  <= ST_FIRE;
        end
        ST_ENV: begin
          if (cur_env != ENV_IDLE) begin
            v_env_q[vidx_q]  <= nx_env;
            v_lvl_q[vidx_q]  <= nx_lvl;
            v_left_q[vidx_q] <= nx_left;
          end
          if (contrib) begin
            v_phase_q[vidx_q] <= v_phase_q[vidx_q] + v_step_q[vidx_q];
            state_q <= ST_SINE;
          end else if (vlast) begin
            state_q <= ST_OUT;
          end else begin
            vidx_q <= vidx_q + VW'(1);
          end
        end
        ST_SINE: if (sine_done) state_q <= ST_MUL1;
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_ACC;
        ST_ACC: begin
          acc_q <= w_neg_q ? acc_q - ACC_W'(prod2_q) : acc_q + ACC_W'(prod2_q);
          if (vlast) begin
            state_q <= ST_OUT;
          end else begin
            vidx_q  <= vidx_q + VW'(1);
            state_q <= ST_ENV;
          end
        end
        ST_OUT: begin
          if (res_push) begin
            if (frame_q != FRAME_MAX) frame_q <= frame_q + 48'd1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `PVS_ASSERT_IMP(a_push_only_out, res_push, state_q == ST_OUT, "sample pushed outside output state")
  `PVS_ASSERT_IMP(a_assign_has_event, state_q == ST_ASSIGN, ev_cnt_q != '0, "voice assigned from empty queue")
  `PVS_ASSERT_NXT(a_overflow_sticky, ovf_q, ovf_q, "overflow flag cleared without reset")
  `PVS_ASSERT_IMP(a_sine_done_waited, sine_done, state_q == ST_SINE, "sine finished while not awaited")

endmodule
